/* src/wspe_pkg.sv */
package wspe_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_BITS     = 6;
  localparam int CNT_BITS     = 7;
  localparam int WEIGHT_BITS  = 16;
  localparam int DIST_BITS    = 24;
  localparam int ADDR_BITS    = 2 * VTX_BITS;

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Input tdata fields, highest bit first.
  typedef struct packed {
    logic [VTX_BITS-1:0]    to_vertex;
    logic [VTX_BITS-1:0]    from_vertex;
    logic [WEIGHT_BITS-1:0] edge_weight;
    logic [VTX_BITS-1:0]    edge_to;
    logic [VTX_BITS-1:0]    edge_from;
  } in_data_t;

  // Request from the search engine to the weight store.
  typedef struct packed {
    logic                   wr_en;
    logic [ADDR_BITS-1:0]   addr;
    logic [WEIGHT_BITS-1:0] wdata;
  } wmem_req_t;

endpackage

/* src/weighted_shortest_path_engine.sv */
// Edge item: no result. Query: per dequeued vertex n+1 weight store reads (one port);
// vertices may leave the queue more than once. Then the path result items follow.
// Items are taken one at a time, and no item is taken while a result waits.
// After reset a clearing pass zeroes all 4096 weight store entries; no item is
// accepted during it. vertex_count resets to 64.
module weighted_shortest_path_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // edge_from, edge_to, edge_weight, from_vertex, to_vertex
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // path_vertex, zero fill
  output logic        out_tuser,  // reachable
  output logic        out_tlast   // last_of_path
);

  logic [wspe_pkg::CNT_BITS-1:0]    vcount_r;
  wspe_pkg::wmem_req_t              wreq;
  logic [wspe_pkg::WEIGHT_BITS-1:0] wrdata;
  logic                             clear_done;
  logic [wspe_pkg::VTX_BITS-1:0]    vtx;
  wspe_pkg::in_data_t               din;

  assign din       = in_tdata;
  assign out_tdata = {2'b00, vtx};

  // Vertex count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= wspe_pkg::CNT_BITS'(wspe_pkg::MAX_VERTICES);
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  wspe_weight_mem u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (wreq),
    .rdata      (wrdata),
    .clear_done (clear_done)
  );

  wspe_search u_search (
    .clk           (clk),
    .rst_n         (rst_n),
    .vertex_count  (vcount_r),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_kind       (in_tuser),
    .in_data       (din),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_reachable (out_tuser),
    .out_vertex    (vtx),
    .out_last      (out_tlast),
    .wreq          (wreq),
    .wrdata        (wrdata),
    .clear_done    (clear_done)
  );

endmodule

/* src/wspe_weight_mem.sv */
// Square edge weight store, row = tail vertex, column = head vertex.
// Cleared by a sweep after reset; one access per cycle, registered read.
module wspe_weight_mem (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wspe_pkg::wmem_req_t              req,
  output logic [wspe_pkg::WEIGHT_BITS-1:0] rdata,
  output logic                             clear_done
);

  logic [wspe_pkg::WEIGHT_BITS-1:0] mem [0:(1 << wspe_pkg::ADDR_BITS)-1];
  logic [wspe_pkg::ADDR_BITS:0]     clr_cnt_r;
  logic [wspe_pkg::ADDR_BITS:0]     clr_cnt_nxt;

  assign clear_done  = clr_cnt_r[wspe_pkg::ADDR_BITS];
  assign clr_cnt_nxt = clr_cnt_r + 1'b1;

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clear_done) begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Memory array.
  always_ff @(posedge clk) begin
    if (!clear_done) begin
      mem[clr_cnt_r[wspe_pkg::ADDR_BITS-1:0]] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

/* src/wspe_search.sv */
// Search sequencer: SPFA over incoming edges, then path trace.
module wspe_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [wspe_pkg::CNT_BITS-1:0]    vertex_count,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_kind,
  input  wspe_pkg::in_data_t               in_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic                             out_reachable,
  output logic [wspe_pkg::VTX_BITS-1:0]    out_vertex,
  output logic                             out_last,
  output wspe_pkg::wmem_req_t              wreq,
  input  logic [wspe_pkg::WEIGHT_BITS-1:0] wrdata,
  input  logic                             clear_done
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RELAX = 3'd3;
  localparam logic [2:0] S_TRACE = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam int VB = wspe_pkg::VTX_BITS;
  localparam int NV = wspe_pkg::MAX_VERTICES;

  logic [2:0]    state_r, state_nxt;
  logic [VB:0]   n_r;
  logic [VB-1:0] src_r, dst_r;
  logic [VB-1:0] u_r;
  logic [VB:0]   i_r;
  logic [VB-1:0] ip_r;
  logic          wv_r;
  logic [wspe_pkg::DIST_BITS-1:0] du_r;
  logic [VB-1:0] q_head_r, q_tail_r;
  logic [VB:0]   q_count_r;
  logic [NV-1:0] reached_r, inq_r;
  logic [VB-1:0] now_r;
  logic [VB:0]   cnt_r;

  // Distance, predecessor and queue memories.
  logic [wspe_pkg::DIST_BITS-1:0] dist_mem [0:NV-1];
  logic [VB-1:0] pred_mem [0:NV-1];
  logic [VB-1:0] queue_mem [0:NV-1];
  logic [VB-1:0] dist_raddr;
  logic [wspe_pkg::DIST_BITS-1:0] dist_rd;
  logic [VB-1:0] pred_rd, queue_rd;
  logic          dist_we, pred_we, queue_we;
  logic [VB-1:0] dist_waddr;
  logic [wspe_pkg::DIST_BITS-1:0] dist_wd;
  logic [VB-1:0] queue_waddr, queue_wd;
  logic [wspe_pkg::DIST_BITS-1:0] cand;
  logic          improve;
  logic          q_push;

  logic [VB:0]   n_eff;
  logic          bad_q;
  logic          out_hold;
  logic          out_load;

  assign n_eff = (vertex_count > wspe_pkg::CNT_BITS'(NV)) ? (VB+1)'(NV) : vertex_count[VB:0];
  assign bad_q = ({1'b0, in_data.from_vertex} >= n_eff) || ({1'b0, in_data.to_vertex} >= n_eff)
                 || (in_data.from_vertex == in_data.to_vertex);
  assign out_hold = out_tvalid && !out_tready;

  assign in_tready = clear_done && (state_r == S_IDLE) && !out_hold;

  // Candidate for the tail read in the previous cycle.
  assign cand    = du_r + wspe_pkg::DIST_BITS'(wrdata);
  assign improve = (wrdata != '0) && (!reached_r[ip_r] || dist_rd > cand);
  assign q_push  = wv_r && improve && !inq_r[ip_r];

  // A new result item is loaded into the output register this cycle.
  assign out_load = ((state_r == S_IDLE) && in_tvalid && in_tready
                     && (in_kind == wspe_pkg::KIND_QUERY) && bad_q)
                    || ((state_r == S_EMIT) && !out_hold);

  // Memory port control.
  always_comb begin
    dist_raddr  = i_r[VB-1:0];
    dist_we     = 1'b0;
    dist_waddr  = ip_r;
    dist_wd     = cand;
    pred_we     = 1'b0;
    queue_we    = 1'b0;
    queue_waddr = q_tail_r;
    queue_wd    = ip_r;
    wreq.wr_en  = 1'b0;
    wreq.addr   = {i_r[VB-1:0], u_r};
    wreq.wdata  = in_data.edge_weight;
    if (state_r == S_IDLE) begin
      wreq.wr_en = in_tvalid && in_tready && (in_kind == wspe_pkg::KIND_EDGE);
      wreq.addr  = {in_data.edge_from, in_data.edge_to};
      dist_we    = in_tvalid && in_tready && (in_kind == wspe_pkg::KIND_QUERY) && !bad_q;
      dist_waddr = in_data.to_vertex;
      dist_wd    = '0;
      queue_we   = dist_we;
      queue_waddr = '0;
      queue_wd   = in_data.to_vertex;
    end else if (state_r == S_SCAN) begin
      // The head entry is valid on queue_rd in this cycle.
      dist_raddr = queue_rd;
    end else if (state_r == S_RELAX && wv_r && improve) begin
      dist_we  = 1'b1;
      pred_we  = 1'b1;
      queue_we = !inq_r[ip_r];
    end
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wd;
    if (pred_we) pred_mem[ip_r] <= u_r;
    if (queue_we) queue_mem[queue_waddr] <= queue_wd;
    dist_rd  <= dist_mem[dist_raddr];
    pred_rd  <= pred_mem[now_r];
    queue_rd <= queue_mem[q_head_r];
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready && in_kind == wspe_pkg::KIND_QUERY && !bad_q) begin
          state_nxt = S_POP;
        end
      end
      S_POP:   state_nxt = S_SCAN;
      S_SCAN:  state_nxt = S_RELAX;
      S_RELAX: begin
        // A push of the last tail also keeps the search going.
        if (i_r == n_r) begin
          state_nxt = (q_count_r == '0 && !q_push) ? S_TRACE : S_POP;
        end
      end
      S_TRACE: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_hold) begin
          if (!reached_r[src_r] || now_r == dst_r || cnt_r + 1'b1 >= n_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_TRACE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_tvalid <= 1'b0;
      reached_r  <= '0;
      inq_r      <= '0;
      q_head_r   <= '0;
      q_tail_r   <= '0;
      q_count_r  <= '0;
      wv_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tvalid && out_tready && !out_load) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready && in_kind == wspe_pkg::KIND_QUERY) begin
            n_r   <= n_eff;
            src_r <= in_data.from_vertex;
            dst_r <= in_data.to_vertex;
            now_r <= in_data.from_vertex;
            cnt_r <= '0;
            if (bad_q) begin
              out_tvalid    <= 1'b1;
              out_reachable <= 1'b0;
              out_vertex    <= '0;
              out_last      <= 1'b1;
            end else begin
              reached_r <= NV'(1) << in_data.to_vertex;
              inq_r     <= NV'(1) << in_data.to_vertex;
              q_head_r  <= '0;
              q_tail_r  <= VB'(1);
              q_count_r <= (VB+1)'(1);
            end
          end
        end
        S_POP: begin
          // Head entry is read onto queue_rd at this edge.
          q_head_r  <= q_head_r + 1'b1;
          q_count_r <= q_count_r - 1'b1;
        end
        S_SCAN: begin
          u_r  <= queue_rd;
          inq_r[queue_rd] <= 1'b0;
          i_r  <= '0;
          wv_r <= 1'b0;
        end
        S_RELAX: begin
          // The distance of the dequeued vertex arrives in the first cycle.
          if (!wv_r) du_r <= dist_rd;
          // Read tail i, evaluate tail ip from the previous read.
          if (wv_r && improve) begin
            reached_r[ip_r] <= 1'b1;
            if (!inq_r[ip_r]) begin
              inq_r[ip_r] <= 1'b1;
              q_tail_r    <= q_tail_r + 1'b1;
              q_count_r   <= q_count_r + 1'b1;
            end
          end
          ip_r <= i_r[VB-1:0];
          wv_r <= (i_r != n_r);
          if (i_r != n_r) i_r <= i_r + 1'b1;
        end
        S_TRACE: begin
        end
        S_EMIT: begin
          if (!out_hold) begin
            out_tvalid <= 1'b1;
            if (!reached_r[src_r]) begin
              out_reachable <= 1'b0;
              out_vertex    <= '0;
              out_last      <= 1'b1;
            end else begin
              out_reachable <= 1'b1;
              out_vertex    <= now_r;
              out_last      <= (now_r == dst_r) || (cnt_r + 1'b1 >= n_r);
              cnt_r         <= cnt_r + 1'b1;
              now_r         <= pred_rd;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
